FILE: sv/isu_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the Ising spin update engine: operation codes,
// init modes and fixed field widths. No dependencies.
package isu_pkg;

   localparam int OP_BITS     = 3;
   localparam int NODE_BITS   = 6;
   localparam int WIN_BITS    = 16;
   localparam int MODE_BITS   = 2;
   localparam int RND_BITS    = 64;
   localparam int CFG_BITS    = 7;
   localparam int ACC_BITS    = 32;

   localparam logic [CFG_BITS-1:0] NODES_RESET = 7'd64;

   localparam logic [OP_BITS-1:0] OP_WR_COUPLING = 3'd0;
   localparam logic [OP_BITS-1:0] OP_WR_BIAS     = 3'd1;
   localparam logic [OP_BITS-1:0] OP_INIT        = 3'd2;
   localparam logic [OP_BITS-1:0] OP_FLIP        = 3'd3;
   localparam logic [OP_BITS-1:0] OP_UPDATE      = 3'd4;
   localparam logic [OP_BITS-1:0] OP_RECORD      = 3'd5;
   localparam logic [OP_BITS-1:0] OP_READ        = 3'd6;

   localparam logic [MODE_BITS-1:0] INIT_ALL_MINUS = 2'd0;
   localparam logic [MODE_BITS-1:0] INIT_ALL_PLUS  = 2'd1;

endpackage

FILE: sv/isu_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the Ising spin update engine.
// Depends on isu_pkg for field widths.
interface isu_req_if;
   logic                                valid;
   logic                                ready;
   logic [isu_pkg::OP_BITS-1:0]         op;
   logic [isu_pkg::NODE_BITS-1:0]       row_node;
   logic [isu_pkg::NODE_BITS-1:0]       col_node;
   logic signed [isu_pkg::WIN_BITS-1:0] weight_value;
   logic [isu_pkg::MODE_BITS-1:0]       init_mode;
   logic [isu_pkg::RND_BITS-1:0]        random_word;
   modport source (output valid, op, row_node, col_node, weight_value, init_mode,
                   random_word, input ready);
   modport sink (input valid, op, row_node, col_node, weight_value, init_mode,
                 random_word, output ready);
endinterface

interface isu_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                spin_out;
   logic                                best_spin_out;
   logic signed [isu_pkg::ACC_BITS-1:0] energy_out;
   logic                                improved;
   modport source (output valid, spin_out, best_spin_out, energy_out, improved,
                   input ready);
   modport sink (input valid, spin_out, best_spin_out, energy_out, improved,
                 output ready);
endinterface

interface isu_csr_if;
   logic                              valid;
   logic                              ready;
   logic [isu_pkg::CFG_BITS-1:0]      data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

FILE: sv/isu_coupling_ram.sv
`timescale 1ns / 1ps
// Coupling matrix storage: one write port, one read port, registered read.
// No dependencies.
module isu_coupling_ram #(
   parameter int ADDR_BITS = 12,
   parameter int DATA_BITS = 16
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: sv/ising_spin_update_engine.sv
`timescale 1ns / 1ps
// Ising spin update engine, top level. Depends on isu_pkg, isu_if, isu_coupling_ram.
// Writes, init, flip and read answer in the cycle after the transfer; update walks
// row k and column k (one coupling read per cycle), then reads the bias; record
// best makes one full matrix walk with n bias reads.
// One item at a time; the single coupling memory read port sets the rate.
// Reset (synchronous, active high): spins all -1, node count 64, memories untouched.
module ising_spin_update_engine #(
   parameter int MAX_NODES   = 64,
   parameter int WEIGHT_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   isu_req_if.sink   req_bus,
   isu_rsp_if.source rsp_bus,
   isu_csr_if.sink   csr_bus
);

   localparam int IW = $clog2(MAX_NODES);
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int AW = 2 * IW;
   localparam int WB = WEIGHT_BITS;
   localparam int AB = isu_pkg::ACC_BITS;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_FIN   = 2'd3;

   // control and state registers
   logic [1:0]                  state_ff, state_in;
   logic                        rec_ff, rec_in;
   logic [IW-1:0]               row_ff, row_in;
   logic                        row_ok_ff, row_ok_in;
   logic                        rnd0_ff, rnd0_in;
   logic [IW-1:0]               i_ff, i_in;
   logic [CW-1:0]               j_ff, j_in;
   logic                        ph_ff, ph_in;
   logic [AB-1:0]               acc_a_ff, acc_a_in;
   logic [AB-1:0]               acc_b_ff, acc_b_in;
   logic                        rd_valid_ff, rd_valid_in;
   logic                        rd_bias_ff, rd_bias_in;
   logic                        pos_a_ff, pos_a_in;
   logic                        pos_b_ff, pos_b_in;
   logic [MAX_NODES-1:0]        cur_ff, cur_in;
   logic [MAX_NODES-1:0]        best_ff, best_in;
   logic [isu_pkg::CFG_BITS-1:0] nodes_ff, nodes_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_spin_ff, rsp_spin_in;
   logic                        rsp_best_ff, rsp_best_in;
   logic [AB-1:0]               rsp_energy_ff, rsp_energy_in;
   logic                        rsp_impr_ff, rsp_impr_in;

   // memories
   logic [WB-1:0]  bias_mem [MAX_NODES];
   logic [WB-1:0]  bias_q;
   logic [WB-1:0]  coup_q;
   logic           coup_we, bias_we;
   logic [AW-1:0]  coup_waddr, coup_raddr;
   logic [IW-1:0]  bias_raddr;
   logic [WB-1:0]  wr_data;

   // effective node count
   logic [31:0]    cfg_ext, n32;
   logic [CW-1:0]  n_cnt, n_m1;

   always_comb begin
      cfg_ext = (nodes_ff == '0) ? 32'd1 : 32'(nodes_ff);
      n32     = (cfg_ext > 32'(MAX_NODES)) ? 32'(MAX_NODES) : cfg_ext;
      n_cnt   = n32[CW-1:0];
      n_m1    = n_cnt - CW'(1);
   end

   // input decode
   logic [31:0]          row_w, col_w;
   logic [IW-1:0]        row_idx, col_idx;
   logic                 row_ok, col_ok, row_act;
   logic signed [31:0]   win32;
   logic [MAX_NODES-1:0] rnd_vec, init_vec;
   logic                 accept, out_free;

   always_comb begin
      row_w   = 32'(req_bus.row_node);
      col_w   = 32'(req_bus.col_node);
      row_idx = row_w[IW-1:0];
      col_idx = col_w[IW-1:0];
      row_ok  = row_w < 32'(MAX_NODES);
      col_ok  = col_w < 32'(MAX_NODES);
      row_act = row_w < n32;
      win32   = 32'(req_bus.weight_value);
      wr_data = win32[WB-1:0];
   end

   for (genvar g = 0; g < MAX_NODES; g++) begin : g_rnd
      assign rnd_vec[g] = req_bus.random_word[g % 64];
   end

   always_comb begin
      if (req_bus.init_mode == isu_pkg::INIT_ALL_MINUS) begin
         init_vec = '0;
      end else if (req_bus.init_mode == isu_pkg::INIT_ALL_PLUS) begin
         init_vec = '1;
      end else begin
         init_vec = rnd_vec;
      end
   end

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE) && out_free;
   assign accept        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign coup_we    = accept && (req_bus.op == isu_pkg::OP_WR_COUPLING) && row_ok && col_ok;
   assign bias_we    = accept && (req_bus.op == isu_pkg::OP_WR_BIAS) && row_ok;
   assign coup_waddr = {row_idx, col_idx};

   // walk issue stage: one memory read per cycle; j == n selects the bias entry
   logic          bias_step, last_step, iss_use, iss_pa, iss_pb;
   logic [IW-1:0] jix;

   always_comb begin
      jix       = j_ff[IW-1:0];
      bias_step = (j_ff == n_cnt);
      if (rec_ff) begin
         coup_raddr = {i_ff, jix};
         bias_raddr = i_ff;
         iss_use    = 1'b1;
         iss_pa     = bias_step ? cur_ff[i_ff] : (cur_ff[i_ff] == cur_ff[jix]);
         iss_pb     = bias_step ? best_ff[i_ff] : (best_ff[i_ff] == best_ff[jix]);
         last_step  = bias_step && (CW'(i_ff) == n_m1);
      end else begin
         coup_raddr = ph_ff ? {jix, row_ff} : {row_ff, jix};
         bias_raddr = row_ff;
         iss_use    = bias_step || (jix != row_ff);
         iss_pa     = bias_step ? 1'b1 : cur_ff[jix];
         iss_pb     = 1'b0;
         last_step  = bias_step;
      end
   end

   // accumulate stage
   logic [AB-1:0]         term;
   logic signed [WB-1:0]  wsel;

   always_comb begin
      wsel = rd_bias_ff ? bias_q : coup_q;
      term = AB'(wsel);
   end

   // finishing values
   logic [MAX_NODES-1:0] cur_fin, best_fin;
   logic                 upd_spin, fin_impr;

   always_comb begin
      if ($signed(acc_a_ff) > 0) begin
         upd_spin = 1'b0;
      end else if ($signed(acc_a_ff) < 0) begin
         upd_spin = 1'b1;
      end else begin
         upd_spin = rnd0_ff;
      end
      cur_fin  = cur_ff;
      best_fin = best_ff;
      fin_impr = 1'b0;
      if (rec_ff) begin
         if ($signed(acc_a_ff) < $signed(acc_b_ff)) begin
            best_fin = cur_ff;
            fin_impr = 1'b1;
         end
      end else begin
         cur_fin[row_ff] = upd_spin;
      end
   end

   // next-state logic
   logic [MAX_NODES-1:0] cur_nx, best_nx;

   always_comb begin
      state_in      = state_ff;
      rec_in        = rec_ff;
      row_in        = row_ff;
      row_ok_in     = row_ok_ff;
      rnd0_in       = rnd0_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      ph_in         = ph_ff;
      acc_a_in      = acc_a_ff;
      acc_b_in      = acc_b_ff;
      rd_valid_in   = 1'b0;
      rd_bias_in    = rd_bias_ff;
      pos_a_in      = pos_a_ff;
      pos_b_in      = pos_b_ff;
      cur_in        = cur_ff;
      best_in       = best_ff;
      nodes_in      = nodes_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_spin_in   = rsp_spin_ff;
      rsp_best_in   = rsp_best_ff;
      rsp_energy_in = rsp_energy_ff;
      rsp_impr_in   = rsp_impr_ff;
      cur_nx        = cur_ff;
      best_nx       = best_ff;

      if (csr_bus.valid && csr_bus.ready) begin
         nodes_in = csr_bus.data;
      end

      // accumulate returning read data
      if (rd_valid_ff) begin
         acc_a_in = pos_a_ff ? acc_a_ff + term : acc_a_ff - term;
         acc_b_in = pos_b_ff ? acc_b_ff + term : acc_b_ff - term;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               row_in    = row_idx;
               row_ok_in = row_ok;
               rnd0_in   = req_bus.random_word[0];
               i_in      = '0;
               j_in      = '0;
               ph_in     = 1'b0;
               acc_a_in  = '0;
               acc_b_in  = '0;
               if (req_bus.op == isu_pkg::OP_INIT) begin
                  cur_nx  = init_vec;
                  best_nx = init_vec;
               end else if (req_bus.op == isu_pkg::OP_FLIP && row_act) begin
                  cur_nx[row_idx] = !cur_ff[row_idx];
               end
               cur_in  = cur_nx;
               best_in = best_nx;
               if (req_bus.op == isu_pkg::OP_RECORD) begin
                  rec_in   = 1'b1;
                  state_in = ST_WALK;
               end else if (req_bus.op == isu_pkg::OP_UPDATE && row_act) begin
                  rec_in   = 1'b0;
                  state_in = ST_WALK;
               end else begin
                  // short ops answer at once
                  rsp_valid_in  = 1'b1;
                  rsp_spin_in   = row_ok && cur_nx[row_idx];
                  rsp_best_in   = row_ok && best_nx[row_idx];
                  rsp_energy_in = '0;
                  rsp_impr_in   = 1'b0;
               end
            end
         end
         ST_WALK: begin
            rd_valid_in = iss_use;
            rd_bias_in  = bias_step;
            pos_a_in    = iss_pa;
            pos_b_in    = iss_pb;
            if (bias_step) begin
               j_in  = '0;
               ph_in = 1'b0;
               i_in  = i_ff + IW'(1);
            end else if (rec_ff || ph_ff) begin
               j_in  = j_ff + CW'(1);
               ph_in = 1'b0;
            end else begin
               ph_in = 1'b1;
            end
            if (last_step) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // hold until the result register frees up
            if (out_free) begin
               cur_in        = cur_fin;
               best_in       = best_fin;
               rsp_valid_in  = 1'b1;
               rsp_spin_in   = row_ok_ff && cur_fin[row_ff];
               rsp_best_in   = row_ok_ff && best_fin[row_ff];
               rsp_energy_in = rec_ff ? acc_a_ff : '0;
               rsp_impr_in   = fin_impr;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         cur_ff       <= '0;
         best_ff      <= '0;
         nodes_ff     <= isu_pkg::NODES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         cur_ff       <= cur_in;
         best_ff      <= best_in;
         nodes_ff     <= nodes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rec_ff        <= rec_in;
      row_ff        <= row_in;
      row_ok_ff     <= row_ok_in;
      rnd0_ff       <= rnd0_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      ph_ff         <= ph_in;
      acc_a_ff      <= acc_a_in;
      acc_b_ff      <= acc_b_in;
      rd_bias_ff    <= rd_bias_in;
      pos_a_ff      <= pos_a_in;
      pos_b_ff      <= pos_b_in;
      rsp_spin_ff   <= rsp_spin_in;
      rsp_best_ff   <= rsp_best_in;
      rsp_energy_ff <= rsp_energy_in;
      rsp_impr_ff   <= rsp_impr_in;
   end

   // bias memory, registered read
   always_ff @(posedge clock) begin
      if (bias_we) begin
         bias_mem[row_idx] <= wr_data;
      end
      bias_q <= bias_mem[bias_raddr];
   end

   isu_coupling_ram #(
      .ADDR_BITS (AW),
      .DATA_BITS (WB)
   ) u_coupling (
      .clock   (clock),
      .wr_en   (coup_we),
      .wr_addr (coup_waddr),
      .wr_data (wr_data),
      .rd_addr (coup_raddr),
      .rd_data (coup_q)
   );

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.spin_out      = rsp_spin_ff;
   assign rsp_bus.best_spin_out = rsp_best_ff;
   assign rsp_bus.energy_out    = rsp_energy_ff;
   assign rsp_bus.improved      = rsp_impr_ff;

endmodule

FILE: sv/isu_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the Ising spin update engine, bound to the top level.
// No package dependency.
module isu_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_spin,
   input logic rsp_best,
   input logic rsp_improved
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_no_take_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !(req_valid && req_ready))
      else $error("item taken while result register full");

   a_improved_copy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_improved |-> rsp_spin == rsp_best)
      else $error("improved result with best spin differing from current");

endmodule

bind ising_spin_update_engine isu_checker u_isu_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_spin     (rsp_bus.spin_out),
   .rsp_best     (rsp_bus.best_spin_out),
   .rsp_improved (rsp_bus.improved)
);

FILE: tb/tb_ising_spin_update_engine.sv
`timescale 1ns / 1ps
// Self-checking testbench for ising_spin_update_engine: drives request and
// register transfers, predicts every response and checks it field by field.
// Depends on isu_pkg and the isu_req_if, isu_rsp_if and isu_csr_if interfaces.
module tb_ising_spin_update_engine;

   localparam int NODES = 64;

   localparam logic [isu_pkg::OP_BITS-1:0]   OP_NONE         = 3'd7;
   localparam logic [isu_pkg::MODE_BITS-1:0] INIT_RANDOM     = 2'd2;
   localparam logic [isu_pkg::MODE_BITS-1:0] INIT_RANDOM_ALT = 2'd3;

   typedef struct {
      logic [isu_pkg::OP_BITS-1:0]         op;
      logic [isu_pkg::NODE_BITS-1:0]       row;
      logic [isu_pkg::NODE_BITS-1:0]       col;
      logic signed [isu_pkg::WIN_BITS-1:0] weight;
      logic [isu_pkg::MODE_BITS-1:0]       mode;
      logic [isu_pkg::RND_BITS-1:0]        rnd;
   } spin_req_type;

   typedef struct {
      logic                                spin;
      logic                                best;
      logic signed [isu_pkg::ACC_BITS-1:0] energy;
      logic                                improved;
   } spin_rsp_type;

   logic clock;
   logic reset;

   isu_req_if req_bus ();
   isu_rsp_if rsp_bus ();
   isu_csr_if csr_bus ();

   ising_spin_update_engine dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Shadow state of the engine.
   logic signed [isu_pkg::ACC_BITS-1:0] coupling_shadow [NODES][NODES];
   logic signed [isu_pkg::ACC_BITS-1:0] bias_shadow [NODES];
   bit                                  coupling_written [NODES][NODES];
   bit                                  bias_written [NODES];
   logic [NODES-1:0]                    spins_now;
   logic [NODES-1:0]                    spins_best;
   int                                  node_count;      // register value as written
   bit                                  allow_record;

   spin_rsp_type pending_rsp [$];
   int           mismatch_count;
   bit           rsp_no_idle;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Generous fixed limit on the whole run.
   initial begin
      #50ms;
      $display("Simulation FAILED");
      $finish;
   end

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return 0;
      if (r < 9) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int active_count();
      if (node_count == 0) return 1;
      if (node_count > NODES) return NODES;
      return node_count;
   endfunction

   function automatic logic signed [isu_pkg::ACC_BITS-1:0] spin_energy(logic [NODES-1:0] s);
      logic signed [isu_pkg::ACC_BITS-1:0] acc;
      int n;
      acc = 0;
      n = active_count();
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++)
            acc += (s[i] == s[j]) ? coupling_shadow[i][j] : -coupling_shadow[i][j];
         acc += s[i] ? bias_shadow[i] : -bias_shadow[i];
      end
      return acc;
   endfunction

   // Advance the shadow state by one request and return its response.
   function automatic spin_rsp_type apply_request(spin_req_type rq);
      spin_rsp_type rs;
      logic signed [isu_pkg::ACC_BITS-1:0] field;
      logic signed [isu_pkg::ACC_BITS-1:0] best_e;
      int n;
      int k;
      n = active_count();
      k = int'(rq.row);
      rs.energy = 0;
      rs.improved = 1'b0;
      case (rq.op)
         isu_pkg::OP_WR_COUPLING: begin
            coupling_shadow[rq.row][rq.col] = 32'(rq.weight);
            coupling_written[rq.row][rq.col] = 1'b1;
         end
         isu_pkg::OP_WR_BIAS: begin
            bias_shadow[rq.row] = 32'(rq.weight);
            bias_written[rq.row] = 1'b1;
         end
         isu_pkg::OP_INIT: begin
            if (rq.mode == isu_pkg::INIT_ALL_MINUS) spins_now = '0;
            else if (rq.mode == isu_pkg::INIT_ALL_PLUS) spins_now = '1;
            else spins_now = rq.rnd;
            spins_best = spins_now;
         end
         isu_pkg::OP_FLIP: if (k < n) spins_now[k] = ~spins_now[k];
         isu_pkg::OP_UPDATE: if (k < n) begin
            field = bias_shadow[k];
            for (int j = 0; j < n; j++) begin
               if (j != k) begin
                  field += spins_now[j] ? coupling_shadow[k][j] : -coupling_shadow[k][j];
                  field += spins_now[j] ? coupling_shadow[j][k] : -coupling_shadow[j][k];
               end
            end
            if (field > 0) spins_now[k] = 1'b0;
            else if (field < 0) spins_now[k] = 1'b1;
            else spins_now[k] = rq.rnd[0];
         end
         isu_pkg::OP_RECORD: begin
            best_e = spin_energy(spins_best);
            rs.energy = spin_energy(spins_now);
            if (rs.energy < best_e) begin
               spins_best = spins_now;
               rs.improved = 1'b1;
            end
         end
         default: ;
      endcase
      rs.spin = spins_now[k];
      rs.best = spins_best[k];
      return rs;
   endfunction

   // Send one request transfer and queue its predicted response.
   task automatic send_request(spin_req_type rq);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.op           <= rq.op;
      req_bus.row_node     <= rq.row;
      req_bus.col_node     <= rq.col;
      req_bus.weight_value <= rq.weight;
      req_bus.init_mode    <= rq.mode;
      req_bus.random_word  <= rq.rnd;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_rsp.push_back(apply_request(rq));
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the node count register while the engine is idle.
   task automatic write_node_count(int value);
      wait_drained();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value[isu_pkg::CFG_BITS-1:0];
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      node_count = value;
      @(posedge clock);
   endtask

   function automatic spin_req_type make_req(logic [isu_pkg::OP_BITS-1:0] op, int row,
                                             int col, int weight, int mode,
                                             logic [isu_pkg::RND_BITS-1:0] rnd);
      spin_req_type rq;
      rq.op = op;
      rq.row = row[isu_pkg::NODE_BITS-1:0];
      rq.col = col[isu_pkg::NODE_BITS-1:0];
      rq.weight = weight[isu_pkg::WIN_BITS-1:0];
      rq.mode = mode[isu_pkg::MODE_BITS-1:0];
      rq.rnd = rnd;
      return rq;
   endfunction

   function automatic logic [isu_pkg::RND_BITS-1:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   // Turn a request that would read unwritten memory into a write of a
   // missing entry. Return 1 when the request was replaced.
   function automatic bit fill_missing(ref spin_req_type rq);
      int n;
      int lo;
      int hi;
      n = active_count();
      if (rq.op == isu_pkg::OP_UPDATE && rq.row < n) begin
         lo = int'(rq.row); hi = int'(rq.row);
      end else if (rq.op == isu_pkg::OP_RECORD) begin
         lo = 0; hi = n - 1;
      end else return 1'b0;
      for (int i = lo; i <= hi; i++) begin
         if (!bias_written[i]) begin
            rq = make_req(isu_pkg::OP_WR_BIAS, i, $urandom_range(0, 63),
                          $urandom_range(0, 65535), $urandom_range(0, 3), rand_word());
            return 1'b1;
         end
         for (int j = 0; j < n; j++) begin
            if (rq.op == isu_pkg::OP_UPDATE && j == i) continue;
            if (!coupling_written[i][j]) begin
               rq = make_req(isu_pkg::OP_WR_COUPLING, i, j, $urandom_range(0, 65535),
                             $urandom_range(0, 3), rand_word());
               return 1'b1;
            end
            if (!coupling_written[j][i]) begin
               rq = make_req(isu_pkg::OP_WR_COUPLING, j, i, $urandom_range(0, 65535),
                             $urandom_range(0, 3), rand_word());
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   // Extremes of the weights, every op, tie break, out-of-range nodes, unused op.
   task automatic test_directed();
      write_node_count(2);
      send_request(make_req(isu_pkg::OP_WR_COUPLING, 0, 0, -32768, 0, '0));
      send_request(make_req(isu_pkg::OP_WR_COUPLING, 1, 1, 32767, 0, '0));
      send_request(make_req(isu_pkg::OP_WR_COUPLING, 0, 1, 5, 0, '0));
      send_request(make_req(isu_pkg::OP_WR_COUPLING, 1, 0, -5, 0, '0));
      send_request(make_req(isu_pkg::OP_WR_BIAS, 0, 63, 0, 0, '0));
      send_request(make_req(isu_pkg::OP_WR_BIAS, 1, 0, -32768, INIT_RANDOM_ALT, '1));
      send_request(make_req(isu_pkg::OP_INIT, 0, 0, 0, isu_pkg::INIT_ALL_PLUS, '0));
      send_request(make_req(isu_pkg::OP_RECORD, 1, 0, 0, 0, '0));
      send_request(make_req(isu_pkg::OP_INIT, 1, 0, 0, isu_pkg::INIT_ALL_MINUS, '1));
      send_request(make_req(isu_pkg::OP_UPDATE, 0, 0, 0, 0, 64'h1));   // zero field, tie to +1
      send_request(make_req(isu_pkg::OP_UPDATE, 0, 0, 0, 0, 64'h0));   // zero field, tie to -1
      send_request(make_req(isu_pkg::OP_UPDATE, 1, 0, 0, 0, '0));
      send_request(make_req(isu_pkg::OP_UPDATE, 9, 0, 0, 0, '1));      // beyond node count
      send_request(make_req(isu_pkg::OP_FLIP, 0, 0, 0, 0, '0));
      send_request(make_req(isu_pkg::OP_FLIP, 5, 0, 0, 0, '0));        // beyond node count
      send_request(make_req(isu_pkg::OP_RECORD, 0, 0, 0, 0, '0));
      send_request(make_req(isu_pkg::OP_INIT, 63, 0, 0, INIT_RANDOM, 64'hA5A5_0F0F_FFFF_0001));
      send_request(make_req(isu_pkg::OP_INIT, 62, 0, 0, INIT_RANDOM_ALT,
                            64'h5A5A_F0F0_0000_FFFE));
      send_request(make_req(isu_pkg::OP_RECORD, 1, 0, 0, 0, '0));
      send_request(make_req(isu_pkg::OP_READ, 63, 0, 0, 0, '0));
      send_request(make_req(OP_NONE, 62, 63, -1, INIT_RANDOM_ALT, '1));
   endtask

   // Random traffic under one node count setting.
   task automatic test_random(int count_value, int items, bit with_record);
      spin_req_type rq;
      int n;
      int r;
      int pick;
      write_node_count(count_value);
      allow_record = with_record;
      n = active_count();
      for (int t = 0; t < items; t++) begin
         rq = make_req(isu_pkg::OP_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                       $urandom_range(0, 65535), $urandom_range(0, 3), rand_word());
         r = $urandom_range(0, 99);
         if (r < 12) rq.op = isu_pkg::OP_WR_COUPLING;
         else if (r < 18) rq.op = isu_pkg::OP_WR_BIAS;
         else if (r < 24) rq.op = isu_pkg::OP_INIT;
         else if (r < 36) rq.op = isu_pkg::OP_FLIP;
         else if (r < 70) rq.op = isu_pkg::OP_UPDATE;
         else if (r < 84) rq.op = allow_record ? isu_pkg::OP_RECORD : isu_pkg::OP_UPDATE;
         else if (r < 96) rq.op = isu_pkg::OP_READ;
         else rq.op = OP_NONE;
         if ((rq.op == isu_pkg::OP_FLIP || rq.op == isu_pkg::OP_UPDATE) &&
             $urandom_range(0, 9) != 0) begin
            pick = $urandom_range(0, n - 1);
            rq.row = pick[isu_pkg::NODE_BITS-1:0];
         end
         void'(fill_missing(rq));
         send_request(rq);
      end
   endtask

   // Accept response transfers and compare against the oldest prediction.
   always @(posedge clock) begin
      spin_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response at %0t", $realtime);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_bus.spin_out !== want.spin || rsp_bus.best_spin_out !== want.best ||
                rsp_bus.energy_out !== want.energy || rsp_bus.improved !== want.improved) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch at %0t: spin %b/%b best %b/%b energy %0d/%0d impr %b/%b",
                           $realtime, want.spin, rsp_bus.spin_out, want.best,
                           rsp_bus.best_spin_out, want.energy, rsp_bus.energy_out,
                           want.improved, rsp_bus.improved);
            end
         end
      end
   end

   // Stall the response side at random, with stretches of no stall.
   initial begin
      int g;
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_no_idle) rsp_bus.ready <= 1'b1;
         else begin
            g = pick_gap();
            if (g > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (g) @(posedge clock);
            end
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      int wait_cycles;
      mismatch_count = 0;
      rsp_no_idle = 1'b0;
      allow_record = 1'b1;
      node_count = int'(isu_pkg::NODES_RESET);
      spins_now = '0;
      spins_best = '0;
      for (int i = 0; i < NODES; i++) begin
         bias_written[i] = 1'b0;
         bias_shadow[i] = 0;
         for (int j = 0; j < NODES; j++) begin
            coupling_written[i][j] = 1'b0;
            coupling_shadow[i][j] = 0;
         end
      end
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.op <= isu_pkg::OP_READ;
      req_bus.row_node <= '0;
      req_bus.col_node <= '0;
      req_bus.weight_value <= '0;
      req_bus.init_mode <= '0;
      req_bus.random_word <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.data <= isu_pkg::NODES_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(1, 100, 1'b1);
      test_random(0, 80, 1'b1);
      test_random(2, 200, 1'b1);
      rsp_no_idle = 1'b1;
      test_random(5, 300, 1'b1);
      rsp_no_idle = 1'b0;
      test_random(8, 300, 1'b1);
      test_random(64, 300, 1'b0);
      test_random(127, 200, 1'b0);
      test_random(3, 300, 1'b1);

      // Drain with a limit, then keep watching for stray responses.
      req_bus.valid <= 1'b0;
      wait_cycles = 0;
      while (pending_rsp.size() != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (pending_rsp.size() != 0) mismatch_count++;
      repeat (200) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/isu_pkg.sv
sv/isu_if.sv
sv/isu_coupling_ram.sv
sv/ising_spin_update_engine.sv
sv/isu_checker.sv
tb/tb_ising_spin_update_engine.sv
